[sv/gvn_pkg.sv]
// Package for the grid vertex normal unit.
// Holds default sizes and the sequencer state type; no dependencies.
package gvn_pkg;

  localparam int DefMaxRows   = 64;
  localparam int DefMaxCols   = 64;
  localparam int DefCoordWidth = 16;

  localparam int SpanWidth  = 6;
  localparam int OutWidth   = 16;
  localparam int MagWidth   = 15;
  localparam int SumWidth   = 32;
  localparam int OpWidth    = 33;
  localparam int UnitBits   = 15;

  localparam logic ActStore = 1'b0;
  localparam logic ActQuery = 1'b1;

  localparam logic RegRowSpans = 1'b0;
  localparam logic RegColSpans = 1'b1;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_READ  = 12'b000000000010,
    ST_TANG  = 12'b000000000100,
    ST_CROSS = 12'b000000001000,
    ST_ABS   = 12'b000000010000,
    ST_SHIFT = 12'b000000100000,
    ST_SUMSQ = 12'b000001000000,
    ST_TGT   = 12'b000010000000,
    ST_BITA  = 12'b000100000000,
    ST_BITB  = 12'b001000000000,
    ST_BITC  = 12'b010000000000,
    ST_FIN   = 12'b100000000000
  } state_t;

endpackage

[sv/grid_vertex_normal_unit.sv]
// Grid vertex normal unit: vertex store, tangent and cross product datapath,
// and an iterative normalizer around one shared multiplier. Uses gvn_pkg.
//
// Usage: a word is accepted when start is high and busy is low. A store word
// (action 0) writes one position and returns nothing; busy stays low. A query
// word (action 1) returns one result word, marked by a one-cycle done strobe.
// A query beyond the configured grid answers in the cycle after it is
// accepted, with bad_index set. Any other query reads four neighbors, forms
// the tangents and then the cross product on the shared multiplier. A zero
// cross product ends the query with degenerate set. Otherwise the cross
// product is shifted down one bit per cycle until it fits in 15 bits, squares
// are summed and each normal component is found bit by bit, with a setup state
// ST_TGT and then ST_BITA, ST_BITB and ST_BITC for each of the fifteen bits.
// A new word can be accepted in the done cycle.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must do so only while idle, as the block itself does not enforce it.
// Reset sets both spans to one and returns to idle; the vertex store is not
// cleared. The receiver cannot stall: a result is valid only in its done cycle.
module grid_vertex_normal_unit #(
  parameter int MAX_ROWS    = gvn_pkg::DefMaxRows,
  parameter int MAX_COLS    = gvn_pkg::DefMaxCols,
  parameter int COORD_WIDTH = gvn_pkg::DefCoordWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [5:0]  row,
  input  logic [5:0]  col,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  output logic        done,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic        degenerate,
  output logic        bad_index,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);
  import gvn_pkg::*;

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(Depth);
  localparam int EXTW  = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;
  localparam int VW    = 3 * COORD_WIDTH;
  localparam int TW    = COORD_WIDTH + 2;
  localparam int CW    = 2 * TW + 1;
  localparam int PW    = 2 * OpWidth;

  logic [VW-1:0] mem [Depth];
  logic [VW-1:0] rdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;
  logic [EXTW-1:0] px_ext, py_ext, pz_ext;

  state_t state;
  logic [SpanWidth-1:0] row_spans, column_spans;
  logic [5:0] rhi, rlo, chi, clo;
  logic [5:0] rhi_c, rlo_r;
  logic       rdbl, cdbl;
  logic [2:0] cnt;
  logic [VW-1:0] v [4];
  logic signed [TW-1:0] tr [3];
  logic signed [TW-1:0] tc [3];
  logic signed [CW-1:0] cr [3];
  logic [CW-1:0] m [3];
  logic [2:0] neg;
  logic [SumWidth-1:0] ssum;
  logic [1:0] comp;
  logic [3:0] bidx;
  logic [UnitBits-1:0] n, cand;
  logic [UnitBits-1:0] nres [3];
  logic [PW-1:0] target;
  logic signed [OpWidth-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic accept, in_grid;
  logic [SpanWidth-1:0] cfg_val;
  logic [15:0] dval;

  function automatic logic [AW-1:0] addr_of(logic [5:0] r, logic [5:0] c);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  function automatic logic signed [TW-1:0] coord(logic [VW-1:0] w, int k);
    return TW'($signed(w[k*COORD_WIDTH +: COORD_WIDTH]));
  endfunction

  function automatic logic signed [TW-1:0] tang(logic [VW-1:0] a, logic [VW-1:0] b,
                                                int k, logic dbl);
    logic signed [TW-1:0] d;
    d = coord(a, k) - coord(b, k);
    return dbl ? TW'(d <<< 1) : d;
  endfunction

  function automatic logic signed [OutWidth-1:0] signed_out(logic [UnitBits-1:0] mag,
                                                            logic ng);
    logic signed [OutWidth-1:0] t;
    t = $signed(OutWidth'(mag));
    return ng ? -t : t;
  endfunction

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign in_grid = (row <= row_spans) && (col <= column_spans);
  assign dval   = 16'((17'(cand) << 1) - 17'd1);

  assign wr_en   = accept && (action == ActStore) && (int'(row) < MAX_ROWS)
                   && (int'(col) < MAX_COLS);
  assign wr_addr = addr_of(row, col);
  assign px_ext  = EXTW'($unsigned(pos_x));
  assign py_ext  = EXTW'($unsigned(pos_y));
  assign pz_ext  = EXTW'($unsigned(pos_z));
  assign wr_data = {pz_ext[COORD_WIDTH-1:0], py_ext[COORD_WIDTH-1:0],
                    px_ext[COORD_WIDTH-1:0]};

  assign rd_en = (state == ST_READ) && (cnt < 3'd4);
  always_comb begin
    unique case (cnt[1:0])
      2'd0:    rd_addr = addr_of(rhi, rhi_c);
      2'd1:    rd_addr = addr_of(rlo, rhi_c);
      2'd2:    rd_addr = addr_of(rlo_r, chi);
      default: rd_addr = addr_of(rlo_r, clo);
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_CROSS: begin
        unique case (cnt)
          3'd0: begin mul_a = OpWidth'(tr[1]); mul_b = OpWidth'(tc[2]); end
          3'd1: begin mul_a = OpWidth'(tr[2]); mul_b = OpWidth'(tc[1]); end
          3'd2: begin mul_a = OpWidth'(tr[2]); mul_b = OpWidth'(tc[0]); end
          3'd3: begin mul_a = OpWidth'(tr[0]); mul_b = OpWidth'(tc[2]); end
          3'd4: begin mul_a = OpWidth'(tr[0]); mul_b = OpWidth'(tc[1]); end
          3'd5: begin mul_a = OpWidth'(tr[1]); mul_b = OpWidth'(tc[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_SUMSQ: begin
        if (cnt < 3'd3) begin
          mul_a = $signed(OpWidth'(m[2'(cnt)][MagWidth-1:0]));
          mul_b = mul_a;
        end
      end
      ST_TGT: begin
        mul_a = $signed(OpWidth'(m[comp][MagWidth-1:0]));
        mul_b = mul_a;
      end
      ST_BITA: begin
        mul_a = $signed(OpWidth'(dval));
        mul_b = mul_a;
      end
      ST_BITB: begin
        mul_a = $signed(OpWidth'(prod[SumWidth-1:0]));
        mul_b = $signed(OpWidth'(ssum));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    cfg_val = (cfg_data == '0) ? SpanWidth'(1) : cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      done         <= 1'b0;
      row_spans    <= SpanWidth'(1);
      column_spans <= SpanWidth'(1);
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == RegRowSpans) begin
          row_spans <= (int'(cfg_val) > MAX_ROWS - 1) ? SpanWidth'(MAX_ROWS - 1) : cfg_val;
        end else begin
          column_spans <= (int'(cfg_val) > MAX_COLS - 1) ? SpanWidth'(MAX_COLS - 1)
                                                         : cfg_val;
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && action == ActQuery) begin
            if (!in_grid) begin
              done       <= 1'b1;
              bad_index  <= 1'b1;
              degenerate <= 1'b0;
              normal_x   <= '0;
              normal_y   <= '0;
              normal_z   <= '0;
            end else begin
              rhi   <= (row == row_spans) ? row : row + 6'd1;
              rlo   <= (row == 6'd0) ? row : row - 6'd1;
              rdbl  <= (row == 6'd0) || (row == row_spans);
              chi   <= (col == column_spans) ? col : col + 6'd1;
              clo   <= (col == 6'd0) ? col : col - 6'd1;
              cdbl  <= (col == 6'd0) || (col == column_spans);
              rhi_c <= col;
              rlo_r <= row;
              cnt   <= '0;
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          if (cnt != 3'd0) begin
            v[2'(cnt - 3'd1)] <= rdata;
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            state <= ST_TANG;
          end
        end
        ST_TANG: begin
          for (int k = 0; k < 3; k++) begin
            tr[k] <= tang(v[0], v[1], k, rdbl);
            tc[k] <= tang(v[2], v[3], k, cdbl);
          end
          cnt   <= '0;
          state <= ST_CROSS;
        end
        ST_CROSS: begin
          if (cnt != 3'd0) begin
            if (!cnt[0]) begin
              cr[2'((cnt - 3'd1) >> 1)] <= cr[2'((cnt - 3'd1) >> 1)] - CW'(prod);
            end else begin
              cr[2'((cnt - 3'd1) >> 1)] <= CW'(prod);
            end
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd6) begin
            state <= ST_ABS;
          end
        end
        ST_ABS: begin
          for (int k = 0; k < 3; k++) begin
            neg[k] <= cr[k][CW-1];
            m[k]   <= cr[k][CW-1] ? CW'(-cr[k]) : CW'(cr[k]);
          end
          if (cr[0] == '0 && cr[1] == '0 && cr[2] == '0) begin
            done       <= 1'b1;
            degenerate <= 1'b1;
            bad_index  <= 1'b0;
            normal_x   <= '0;
            normal_y   <= '0;
            normal_z   <= '0;
            state      <= ST_IDLE;
          end else begin
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (((m[0] | m[1] | m[2]) >> MagWidth) != '0) begin
            for (int k = 0; k < 3; k++) begin
              m[k] <= m[k] >> 1;
            end
          end else begin
            cnt   <= '0;
            ssum  <= '0;
            state <= ST_SUMSQ;
          end
        end
        ST_SUMSQ: begin
          if (cnt != 3'd0) begin
            ssum <= ssum + prod[SumWidth-1:0];
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd3) begin
            comp  <= '0;
            bidx  <= 4'(UnitBits - 1);
            n     <= '0;
            state <= ST_TGT;
          end
        end
        ST_TGT: begin
          cand  <= n | (UnitBits'(1) << bidx);
          state <= ST_BITA;
        end
        ST_BITA: begin
          if (bidx == 4'(UnitBits - 1) && n == '0) begin
            target <= PW'(prod[2*MagWidth-1:0]) << 30;
          end
          state <= ST_BITB;
        end
        ST_BITB: begin
          state <= ST_BITC;
        end
        ST_BITC: begin
          if ($unsigned(prod) <= target) begin
            n <= cand;
          end
          if (bidx == 4'd0) begin
            nres[comp] <= ($unsigned(prod) <= target) ? cand : n;
            if (comp == 2'd2) begin
              state <= ST_FIN;
            end else begin
              comp  <= comp + 2'd1;
              bidx  <= 4'(UnitBits - 1);
              n     <= '0;
              state <= ST_TGT;
            end
          end else begin
            bidx  <= bidx - 4'd1;
            cand  <= (($unsigned(prod) <= target) ? cand : n)
                     | (UnitBits'(1) << (bidx - 4'd1));
            state <= ST_BITA;
          end
        end
        ST_FIN: begin
          normal_x   <= signed_out(nres[0], neg[0]);
          normal_y   <= signed_out(nres[1], neg[1]);
          normal_z   <= signed_out(nres[2], neg[2]);
          degenerate <= 1'b0;
          bad_index  <= 1'b0;
          done       <= 1'b1;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_onehot_state: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state is not one-hot");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word while a query is still in progress");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
      done |-> !(degenerate && bad_index))
    else $error("degenerate and bad_index raised together");
  a_zero_normal: assert property (@(posedge clk) disable iff (rst)
      done && (degenerate || bad_index) |->
      normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("flagged result carries a nonzero normal");
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
      accept && action == ActQuery && in_grid |=> busy)
    else $error("valid query did not start the sequencer");

endmodule

[dv/grid_vertex_normal_unit_tb.sv]
// Self-checking testbench for grid_vertex_normal_unit: stores grid positions,
// queries normals and compares each result word with an in-bench predictor.
// Depends on gvn_pkg and the grid_vertex_normal_unit RTL only.
module grid_vertex_normal_unit_tb;
  import gvn_pkg::*;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
    logic               bad;
  } normal_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic action = ActStore;
  logic [5:0] row = '0;
  logic [5:0] col = '0;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic signed [15:0] pos_z = '0;
  logic cfg_we = 1'b0;
  logic cfg_index = RegRowSpans;
  logic [5:0] cfg_data = '0;
  logic busy, done, degenerate, bad_index;
  logic signed [15:0] normal_x, normal_y, normal_z;

  grid_vertex_normal_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .row(row), .col(col), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .degenerate(degenerate), .bad_index(bad_index), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic signed [15:0] grid_pos [0:4095][0:2];
  int unsigned row_last = 1;
  int unsigned col_last = 1;
  normal_word_t normals_due [$];
  int errors = 0;
  int queries = 0;
  int stores = 0;
  int sender_idle_pct = 0;
  longint cycles = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic int unsigned scaled_component(longint unsigned m, longint unsigned s);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    longint unsigned d;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      d = 2 * longint'(mid) - 1;
      if (d * d * s <= ((m * m) << 30)) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint grid_coord(int unsigned r, int unsigned c, int k);
    return longint'(grid_pos[r * 64 + c][k]);
  endfunction

  function automatic normal_word_t predict_normal(int unsigned r, int unsigned c);
    normal_word_t w;
    longint tr [3];
    longint tc [3];
    longint cr [3];
    longint unsigned m [3];
    longint unsigned s;
    int unsigned n;
    w = '0;
    if (r > row_last || c > col_last) begin
      w.bad = 1'b1;
      return w;
    end
    for (int k = 0; k < 3; k++) begin
      if (r == 0) tr[k] = 2 * (grid_coord(r + 1, c, k) - grid_coord(r, c, k));
      else if (r == row_last) tr[k] = 2 * (grid_coord(r, c, k) - grid_coord(r - 1, c, k));
      else tr[k] = grid_coord(r + 1, c, k) - grid_coord(r - 1, c, k);
      if (c == 0) tc[k] = 2 * (grid_coord(r, c + 1, k) - grid_coord(r, c, k));
      else if (c == col_last) tc[k] = 2 * (grid_coord(r, c, k) - grid_coord(r, c - 1, k));
      else tc[k] = grid_coord(r, c + 1, k) - grid_coord(r, c - 1, k);
    end
    cr[0] = tr[1] * tc[2] - tr[2] * tc[1];
    cr[1] = tr[2] * tc[0] - tr[0] * tc[2];
    cr[2] = tr[0] * tc[1] - tr[1] * tc[0];
    for (int k = 0; k < 3; k++) m[k] = (cr[k] < 0) ? -cr[k] : cr[k];
    if ((m[0] | m[1] | m[2]) == 0) begin
      w.degen = 1'b1;
      return w;
    end
    while ((m[0] | m[1] | m[2]) >= 64'd32768)
      for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    for (int k = 0; k < 3; k++) begin
      n = scaled_component(m[k], s);
      if (cr[k] < 0) n = -n;
      if (k == 0) w.nx = n[15:0];
      else if (k == 1) w.ny = n[15:0];
      else w.nz = n[15:0];
    end
    return w;
  endfunction

  // Sends one word; stores update the predictor, queries queue a result.
  // Start stays high on return; the next word takes it over or wait_idle drops it.
  task automatic send_word(input logic act, input logic [5:0] r, input logic [5:0] c,
                           input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    action <= act;
    row <= r;
    col <= c;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (act == ActStore) begin
      grid_pos[r * 64 + c][0] = x;
      grid_pos[r * 64 + c][1] = y;
      grid_pos[r * 64 + c][2] = z;
      stores++;
    end else begin
      normals_due.push_back(predict_normal(32'(r), 32'(c)));
      queries++;
    end
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    normal_word_t e;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (normals_due.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        e = normals_due.pop_front();
        if (normal_x !== e.nx) report_mismatch($sformatf("normal_x %0d exp %0d", normal_x, e.nx));
        if (normal_y !== e.ny) report_mismatch($sformatf("normal_y %0d exp %0d", normal_y, e.ny));
        if (normal_z !== e.nz) report_mismatch($sformatf("normal_z %0d exp %0d", normal_z, e.nz));
        if (degenerate !== e.degen) report_mismatch("degenerate flag");
        if (bad_index !== e.bad) report_mismatch("bad_index flag");
      end
    end
    if (cycles > 4000000) begin
      $display("Timeout waiting for result words");
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_idle();
    start <= 1'b0;
    while (normals_due.size() != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_span(input logic idx, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[5:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    value = value & 32'd63;
    if (value < 1) value = 1;
    if (idx == RegRowSpans) row_last = value;
    else col_last = value;
  endtask

  function automatic logic [15:0] rand_coord(input bit small_range);
    if (small_range) return 16'($signed($urandom_range(512)) - 256);
    return 16'($urandom);
  endfunction

  // Fills the configured grid so that every query reads written entries.
  task automatic fill_grid(input int mode);
    for (int r = 0; r <= row_last; r++)
      for (int c = 0; c <= col_last; c++)
        if (mode == 0)
          send_word(ActStore, 6'(r), 6'(c), 16'(c * 256), 16'(r * 256),
                    16'($urandom_range(200)));
        else if (mode == 1)
          send_word(ActStore, 6'(r), 6'(c), 16'(r * 100), 16'(r * 50), 16'(r * 7));
        else
          send_word(ActStore, 6'(r), 6'(c), rand_coord(mode == 2), rand_coord(mode == 2),
                    rand_coord(mode == 2));
  endtask

  task automatic test_directed();
    write_span(RegRowSpans, 1);
    write_span(RegColSpans, 1);
    // Two-by-two grid with extreme corners at full range.
    send_word(ActStore, 6'd0, 6'd0, 16'h8000, 16'h8000, 16'h7FFF);
    send_word(ActStore, 6'd0, 6'd1, 16'h7FFF, 16'h8000, 16'h8000);
    send_word(ActStore, 6'd1, 6'd0, 16'h8000, 16'h7FFF, 16'h0000);
    send_word(ActStore, 6'd1, 6'd1, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 2; c++) send_word(ActQuery, 6'(r), 6'(c), 16'd0, 16'd0, 16'd0);
    // Index beyond the grid, and a store beyond the grid that is kept.
    send_word(ActQuery, 6'd2, 6'd0, 16'd0, 16'd0, 16'd0);
    send_word(ActQuery, 6'd0, 6'd63, 16'd0, 16'd0, 16'd0);
    send_word(ActQuery, 6'd63, 6'd63, 16'd0, 16'd0, 16'd0);
    send_word(ActStore, 6'd63, 6'd63, 16'h1234, 16'h5678, 16'h9ABC);
    // All points equal: zero-length cross product.
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 2; c++)
        send_word(ActStore, 6'(r), 6'(c), 16'h0100, 16'h0100, 16'h0100);
    send_word(ActQuery, 6'd0, 6'd0, 16'd0, 16'd0, 16'd0);
    send_word(ActQuery, 6'd1, 6'd1, 16'd0, 16'd0, 16'd0);
    wait_idle();
  endtask

  task automatic test_random_phase(input int unsigned rs, input int unsigned cs,
                                   input int idle, input int n_items);
    int unsigned r;
    int unsigned c;
    sender_idle_pct = 0;
    write_span(RegRowSpans, rs);
    write_span(RegColSpans, cs);
    fill_grid($urandom_range(3));
    sender_idle_pct = idle;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(9) < 3) begin
        r = $urandom_range(row_last);
        c = $urandom_range(col_last);
        send_word(ActStore, 6'(r), 6'(c), rand_coord(1'($urandom_range(1))),
                  rand_coord(1'($urandom_range(1))), rand_coord(1'($urandom_range(1))));
      end else if ($urandom_range(19) == 0) begin
        send_word(ActQuery, 6'($urandom_range(63)), 6'($urandom_range(63)), 16'($urandom),
                  16'($urandom), 16'($urandom));
      end else begin
        send_word(ActQuery, 6'($urandom_range(row_last)), 6'($urandom_range(col_last)),
                  16'($urandom), 16'($urandom), 16'($urandom));
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_phase(1, 1, 0, 100);
    test_random_phase(63, 1, 0, 100);
    test_random_phase(2, 63, 84, 100);
    test_random_phase(5, 7, 13, 150);
    test_random_phase(3, 4, 84, 120);
    test_random_phase($urandom_range(1, 8), $urandom_range(1, 8), 0, 140);
    $display("Covered %0d stores and %0d queries over several grid sizes and idle rates.",
             stores, queries);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
